// File: design/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
`default_nettype none
package bba_pkg;

  localparam int MAX_LEVELS = 10;
  localparam int NODE_W     = MAX_LEVELS;
  localparam int NODE_SLOTS = 1 << MAX_LEVELS;
  localparam int LVL_W      = 4;
  localparam int LCNT_W     = $clog2(MAX_LEVELS + 1);
  localparam int LCFG_W     = 4;
  localparam int MINB_W     = 13;
  localparam int REQ_W      = 21;
  localparam int OFS_W      = 21;
  localparam int STAT_W     = 3;
  localparam int TOTAL_W    = MINB_W + MAX_LEVELS - 1;
  localparam int NEED_W     = REQ_W + 1;
  localparam int CMP_W      = (TOTAL_W > NEED_W) ? TOTAL_W : NEED_W;
  localparam int PROD_W     = TOTAL_W + NODE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MINB_W;

  localparam logic [NEED_W-1:0] HEADER_BYTES = NEED_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK   = 1'b1;
  localparam logic [LCFG_W-1:0]    RST_LEVEL_COUNT = LCFG_W'(10);
  localparam logic [MINB_W-1:0]    RST_MIN_BLOCK   = MINB_W'(64);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_BUSY  = 3'd4;

  typedef struct packed {
    logic              op;
    logic [REQ_W-1:0]  request_bytes;
    logic [NODE_W-1:0] node_index;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NODE_W-1:0] granted_node;
    logic [LVL_W-1:0]  granted_level;
    logic [OFS_W-1:0]  block_offset;
  } out_t;

  typedef struct packed {
    logic [LCFG_W-1:0] level_count;
    logic [MINB_W-1:0] min_block_bytes;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: design/bba_seq.sv
// Sequencer: level search, level scan, subtree marking, ancestor and merge walks.
`default_nettype none
module bba_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire bba_pkg::in_t                  in_data,
  output logic                               in_ready,
  input  wire bba_pkg::cfg_t                 cfg,
  output logic                               res_valid,
  output bba_pkg::out_t                      res,
  input  wire logic                          res_take,
  output logic                               ram_we,
  output logic [bba_pkg::NODE_W-1:0]         ram_wa,
  output logic                               ram_wd,
  output logic [bba_pkg::NODE_W-1:0]         ram_ra,
  input  wire logic                          ram_rd
);

  localparam int NW  = bba_pkg::NODE_W;
  localparam int NW1 = bba_pkg::NODE_W + 1;

  typedef enum logic [10:0] {
    S_CLR     = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_LVL     = 11'b00000000100,
    S_SCAN    = 11'b00000001000,
    S_MARK    = 11'b00000010000,
    S_ANC_RD  = 11'b00000100000,
    S_ANC_CHK = 11'b00001000000,
    S_FCHK    = 11'b00010000000,
    S_BUD_CHK = 11'b00100000000,
    S_OFS     = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            op_r, op_nxt;
  logic [bba_pkg::LCNT_W-1:0]      levels_r, levels_nxt;
  logic [NW-1:0]                   nodes_r, nodes_nxt;
  logic [bba_pkg::TOTAL_W-1:0]     tot_sh_r, tot_sh_nxt;
  logic [bba_pkg::TOTAL_W-1:0]     blk_r, blk_nxt;
  logic [bba_pkg::NEED_W-1:0]      need_r, need_nxt;
  logic [bba_pkg::LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [bba_pkg::LVL_W-1:0]       sel_r, sel_nxt;
  logic [NW1-1:0]                  k_r, k_nxt;
  logic                            pend_r, pend_nxt;
  logic [NW1-1:0]                  st_r, st_nxt;
  logic [NW1-1:0]                  sp_r, sp_nxt;
  logic                            mval_r, mval_nxt;
  logic [NW-1:0]                   n_r, n_nxt;
  logic [NW-1:0]                   fk_r, fk_nxt;
  logic [NW-1:0]                   clr_r, clr_nxt;
  bba_pkg::out_t                   res_r, res_nxt;

  logic [bba_pkg::LCNT_W-1:0]      lv_eff;
  logic [NW-1:0]                   nodes_c;
  logic                            ge;
  logic [NW1-1:0]                  cnt_c, first_c, st2_c, hit_c;
  logic [NW-1:0]                   parent_c, buddy_c;
  logic [bba_pkg::PROD_W-1:0]      prod_c;

  always_comb begin
    if (cfg.level_count == '0) begin
      lv_eff = bba_pkg::LCNT_W'(1);
    end else if (32'(cfg.level_count) > bba_pkg::MAX_LEVELS) begin
      lv_eff = bba_pkg::LCNT_W'(bba_pkg::MAX_LEVELS);
    end else begin
      lv_eff = bba_pkg::LCNT_W'(cfg.level_count);
    end
  end

  assign nodes_c  = NW'((32'd1 << lv_eff) - 32'd1);
  assign ge       = bba_pkg::CMP_W'(tot_sh_r) >= bba_pkg::CMP_W'(need_r);
  assign cnt_c    = NW1'(1) << sel_r;
  assign first_c  = cnt_c - NW1'(1);
  assign st2_c    = NW1'({st_r[NW-1:0], 1'b1});
  assign hit_c    = first_c + k_r - NW1'(1);
  assign parent_c = NW'((n_r - NW'(1)) >> 1);
  assign buddy_c  = n_r[0] ? (n_r + NW'(1)) : (n_r - NW'(1));
  assign prod_c   = bba_pkg::PROD_W'(blk_r) * bba_pkg::PROD_W'(fk_r);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    levels_nxt = levels_r;
    nodes_nxt  = nodes_r;
    tot_sh_nxt = tot_sh_r;
    blk_nxt    = blk_r;
    need_nxt   = need_r;
    lvl_nxt    = lvl_r;
    sel_nxt    = sel_r;
    k_nxt      = k_r;
    pend_nxt   = pend_r;
    st_nxt     = st_r;
    sp_nxt     = sp_r;
    mval_nxt   = mval_r;
    n_nxt      = n_r;
    fk_nxt     = fk_r;
    clr_nxt    = clr_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_wa     = n_r;
    ram_wd     = 1'b0;
    ram_ra     = n_r;

    unique case (state_r)
      S_CLR: begin
        ram_we  = 1'b1;
        ram_wa  = clr_r;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_ra = in_data.node_index;
        if (in_valid) begin
          op_nxt     = in_data.op;
          levels_nxt = lv_eff;
          nodes_nxt  = nodes_c;
          tot_sh_nxt = bba_pkg::TOTAL_W'(cfg.min_block_bytes)
                       << (lv_eff - bba_pkg::LCNT_W'(1));
          need_nxt   = bba_pkg::NEED_W'(in_data.request_bytes) + bba_pkg::HEADER_BYTES;
          lvl_nxt    = '0;
          res_nxt    = '0;
          n_nxt      = in_data.node_index;
          if (in_data.op == bba_pkg::OP_ALLOC) begin
            state_nxt = S_LVL;
          end else if (in_data.node_index >= nodes_c) begin
            res_nxt.status = bba_pkg::ST_BAD_INDEX;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FCHK;
          end
        end
      end
      S_LVL: begin
        // one shift and compare per level: block at this level still holds the request?
        if (ge) begin
          blk_nxt = tot_sh_r;
          sel_nxt = lvl_r;
          if (32'(lvl_r) == 32'(levels_r) - 1) begin
            k_nxt     = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            lvl_nxt    = lvl_r + bba_pkg::LVL_W'(1);
            tot_sh_nxt = tot_sh_r >> 1;
          end
        end else if (lvl_r == '0) begin
          res_nxt.status = bba_pkg::ST_TOO_LARGE;
          state_nxt      = S_DONE;
        end else begin
          k_nxt     = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_ra = NW'(first_c + k_r);
        if (pend_r && !ram_rd) begin
          fk_nxt               = NW'(k_r - NW1'(1));
          n_nxt                = NW'(hit_c);
          res_nxt.granted_node = NW'(hit_c);
          res_nxt.granted_level = sel_r;
          st_nxt               = hit_c;
          sp_nxt               = NW1'(1);
          k_nxt                = '0;
          mval_nxt             = 1'b1;
          state_nxt            = S_MARK;
        end else if (k_r == cnt_c) begin
          res_nxt.status = bba_pkg::ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          k_nxt    = k_r + NW1'(1);
          pend_nxt = 1'b1;
        end
      end
      S_MARK: begin
        // one node written per cycle, level by level down the subtree
        ram_we = 1'b1;
        ram_wa = NW'(st_r + k_r);
        ram_wd = mval_r;
        ram_ra = buddy_c;
        if (k_r + NW1'(1) == sp_r) begin
          st_nxt = st2_c;
          sp_nxt = sp_r << 1;
          k_nxt  = '0;
          if (st2_c >= NW1'(nodes_r)) begin
            if (op_r == bba_pkg::OP_ALLOC) begin
              state_nxt = S_ANC_RD;
            end else if (n_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_BUD_CHK;
            end
          end
        end else begin
          k_nxt = k_r + NW1'(1);
        end
      end
      S_ANC_RD: begin
        ram_ra = parent_c;
        if (n_r == '0) begin
          state_nxt = S_OFS;
        end else begin
          n_nxt     = parent_c;
          state_nxt = S_ANC_CHK;
        end
      end
      S_ANC_CHK: begin
        if (ram_rd) begin
          state_nxt = S_OFS;
        end else begin
          ram_we    = 1'b1;
          ram_wa    = n_r;
          ram_wd    = 1'b1;
          state_nxt = S_ANC_RD;
        end
      end
      S_FCHK: begin
        if (!ram_rd) begin
          res_nxt.status = bba_pkg::ST_NOT_BUSY;
          state_nxt      = S_DONE;
        end else begin
          st_nxt    = NW1'(n_r);
          sp_nxt    = NW1'(1);
          k_nxt     = '0;
          mval_nxt  = 1'b0;
          state_nxt = S_MARK;
        end
      end
      S_BUD_CHK: begin
        if (ram_rd) begin
          state_nxt = S_DONE;
        end else if (parent_c == '0) begin
          ram_we    = 1'b1;
          ram_wa    = '0;
          ram_wd    = 1'b0;
          state_nxt = S_DONE;
        end else begin
          n_nxt     = parent_c;
          st_nxt    = NW1'(parent_c);
          sp_nxt    = NW1'(1);
          k_nxt     = '0;
          state_nxt = S_MARK;
        end
      end
      S_OFS: begin
        res_nxt.block_offset = prod_c[bba_pkg::OFS_W-1:0];
        state_nxt            = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    levels_r <= levels_nxt;
    nodes_r  <= nodes_nxt;
    tot_sh_r <= tot_sh_nxt;
    blk_r    <= blk_nxt;
    need_r   <= need_nxt;
    lvl_r    <= lvl_nxt;
    sel_r    <= sel_nxt;
    k_r      <= k_nxt;
    pend_r   <= pend_nxt;
    st_r     <= st_nxt;
    sp_r     <= sp_nxt;
    mval_r   <= mval_nxt;
    n_r      <= n_nxt;
    fk_r     <= fk_nxt;
    res_r    <= res_nxt;
  end

endmodule
`default_nettype wire

// File: design/buddy_block_allocator.sv
// Top level of the buddy block allocator: config registers, busy-bit RAM, result register.
// Buddy allocator over a binary tree of busy bits held in a 1024 x 1 RAM, walked by one
// sequencer that reads or writes one tree node per cycle. After reset a clearing pass
// writes every RAM entry before the first input transfer is taken (config writes are
// taken meanwhile). One item is in flight at a time. An allocate searches the levels,
// scans the nodes in the chosen level (up to 2^level of them), marks the subtree and
// sets each clear ancestor; a free clears the subtree on each merge step, with one buddy
// read per step. The longest items are an allocate at the root of a ten-level tree and
// a leaf free that merges all the way up; the RAM port sets the pace throughout.
// A finished result sits in the output register, so the next input transfer is taken
// while the previous result still waits for out_ready.
`default_nettype none
module buddy_block_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bba_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bba_pkg::out_t                          out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bba_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  bba_pkg::cfg_t                  cfg_r, cfg_nxt;
  logic                           out_valid_r, out_valid_nxt;
  bba_pkg::out_t                  out_data_r, out_data_nxt;

  logic                           res_valid, res_take;
  bba_pkg::out_t                  res;
  logic                           ram_we, ram_wd, ram_rd;
  logic [bba_pkg::NODE_W-1:0]     ram_wa, ram_ra;

  // result register loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        bba_pkg::CFG_LEVEL_COUNT: cfg_nxt.level_count     = cfg_wdata[bba_pkg::LCFG_W-1:0];
        bba_pkg::CFG_MIN_BLOCK:   cfg_nxt.min_block_bytes = cfg_wdata[bba_pkg::MINB_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_count     <= bba_pkg::RST_LEVEL_COUNT;
      cfg_r.min_block_bytes <= bba_pkg::RST_MIN_BLOCK;
      out_valid_r           <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bba_ram #(
    .WIDTH(1),
    .DEPTH(bba_pkg::NODE_SLOTS)
  ) u_busy_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  bba_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_wa    (ram_wa),
    .ram_wd    (ram_wd),
    .ram_ra    (ram_ra),
    .ram_rd    (ram_rd)
  );

endmodule
`default_nettype wire

// File: design/bba_checker.sv
// Port-level checks for the buddy block allocator, bound to the top level.
`default_nettype none
module bba_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire bba_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bba_pkg::ST_OK) |->
      (out_data.granted_node == '0) && (out_data.granted_level == '0) &&
      (out_data.block_offset == '0))
    else $error("error result carries nonzero fields");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the buddy block allocator: directed table, then random traffic.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import bba_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  // Long enough for the sequencer to finish an item; settle this long before cfg writes.
  localparam int SETTLE_CYCLES  = 1200;
  localparam int RANDOM_ITEMS   = 1150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  buddy_block_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator: busy bits and the two registers
  bit          tree_busy [NODE_SLOTS];
  logic [3:0]  lvl_cfg;
  logic [12:0] minb_cfg;

  out_t grant_q[$];      // results awaited, oldest first
  int   live_nodes[$];   // nodes handed out, candidates for well-formed frees
  int   mismatches = 0;
  bit   failed = 0;
  bit   quiet = 0;       // no idling on either side while set
  int   stall_cnt = 0;

  function automatic int levels_in_use();
    if (lvl_cfg == 0) return 1;
    if (lvl_cfg > MAX_LEVELS) return MAX_LEVELS;
    return lvl_cfg;
  endfunction

  function automatic void paint_subtree(int n, int nodes, bit val);
    int start, span;
    start = n;
    span = 1;
    while (start < nodes) begin
      for (int k = 0; k < span && start + k < nodes; k++) tree_busy[start + k] = val;
      start = 2 * start + 1;
      span = span << 1;
    end
  endfunction

  // Predicts the result of one request and applies it to the shadow tree
  function automatic out_t predict_grant(in_t req);
    out_t r;
    int levels, nodes, lvl, first, k, n, p, buddy;
    longint unsigned total, need, q;
    bit found;
    r = '0;
    levels = levels_in_use();
    nodes = (1 << levels) - 1;
    if (req.op == OP_ALLOC) begin
      total = longint'(minb_cfg) << (levels - 1);
      need = longint'(req.request_bytes) + 4;
      q = total / need;
      if (q == 0) begin
        r.status = ST_TOO_LARGE;
      end else begin
        lvl = 0;
        while (q > 1) begin
          q = q >> 1;
          lvl++;
        end
        if (lvl >= levels) lvl = levels - 1;
        first = (1 << lvl) - 1;
        found = 0;
        for (k = 0; k < (1 << lvl); k++) begin
          if (!tree_busy[first + k]) begin
            found = 1;
            break;
          end
        end
        if (!found) begin
          r.status = ST_NO_FREE;
        end else begin
          n = first + k;
          paint_subtree(n, nodes, 1'b1);
          p = n;
          while (p != 0) begin
            p = (p - 1) >> 1;
            if (tree_busy[p]) break;
            tree_busy[p] = 1'b1;
          end
          r.status = ST_OK;
          r.granted_node = NODE_W'(n);
          r.granted_level = LVL_W'(lvl);
          r.block_offset = OFS_W'((total >> lvl) * longint'(k));
        end
      end
    end else begin
      n = req.node_index;
      if (n >= nodes) begin
        r.status = ST_BAD_INDEX;
      end else if (!tree_busy[n]) begin
        r.status = ST_NOT_BUSY;
      end else begin
        // clear, then climb while the buddy is clear too
        forever begin
          paint_subtree(n, nodes, 1'b0);
          if (n == 0) break;
          buddy = (n & 1) ? n + 1 : n - 1;
          if (tree_busy[buddy]) break;
          p = (n - 1) >> 1;
          if (p == 0) begin
            tree_busy[0] = 1'b0;
            break;
          end
          n = p;
        end
      end
    end
    return r;
  endfunction

  // Result side: random back-pressure, compare with the oldest expectation
  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        out_t want;
        want = grant_q.pop_front();
        if (out_data !== want) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d node=%0d lvl=%0d ofs=%0d, ",
                      "got st=%0d node=%0d lvl=%0d ofs=%0d"},
                     want.status, want.granted_node, want.granted_level, want.block_offset,
                     out_data.status, out_data.granted_node, out_data.granted_level,
                     out_data.block_offset);
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_LEVEL_COUNT) lvl_cfg = 4'(value);
    else minb_cfg = 13'(value);
  endtask

  task automatic drain();
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Presents one request; returns once the transfer has happened
  task automatic send_request(in_t req, bit typed, out_t typed_res);
    out_t r;
    if (!quiet && $urandom_range(0, 99) < 18) repeat ($urandom_range(1, 4)) @(negedge clk);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    r = predict_grant(req);
    grant_q.push_back(typed ? typed_res : r);
    if (r.status == ST_OK && req.op == OP_ALLOC) live_nodes.push_back(r.granted_node);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  typedef struct {
    logic op;
    int   bytes;
    int   node;
    bit   typed;
    logic [STAT_W-1:0] st;
    int   gnode;
    int   glvl;
  } row_t;

  // Default setting: 10 levels, 64-byte leaves, 32768 bytes in all.
  // Typed rows all have a zero offset.
  row_t dir_rows[] = '{
    '{OP_ALLOC, 0,       0,    1, ST_OK,        511, 9},  // smallest, clamps to leaves
    '{OP_FREE,  0,       1023, 1, ST_BAD_INDEX, 0,   0},  // past the last node
    '{OP_FREE,  0,       5,    1, ST_NOT_BUSY,  0,   0},  // never allocated
    '{OP_ALLOC, 2097151, 0,    1, ST_TOO_LARGE, 0,   0},  // largest request
    '{OP_ALLOC, 32764,   0,    1, ST_NO_FREE,   0,   0},  // whole memory, root taken
    '{OP_FREE,  0,       511,  1, ST_OK,        0,   0},  // merges all the way up
    '{OP_ALLOC, 32764,   0,    1, ST_OK,        0,   0},  // exactly the whole memory
    '{OP_FREE,  0,       0,    1, ST_OK,        0,   0},  // root free clears all
    '{OP_ALLOC, 16380,   0,    0, ST_OK,        0,   0},
    '{OP_ALLOC, 16380,   0,    0, ST_OK,        0,   0},
    '{OP_ALLOC, 16380,   0,    0, ST_OK,        0,   0},  // level one full
    '{OP_FREE,  0,       2,    0, ST_OK,        0,   0},
    '{OP_ALLOC, 100,     0,    0, ST_OK,        0,   0},
    '{OP_ALLOC, 1000,    0,    0, ST_OK,        0,   0},
    '{OP_FREE,  0,       1,    0, ST_OK,        0,   0},
    '{OP_FREE,  0,       1022, 0, ST_OK,        0,   0},  // last node, clear
    '{OP_ALLOC, 60,      0,    0, ST_OK,        0,   0},
    '{OP_ALLOC, 61,      0,    0, ST_OK,        0,   0},
    '{OP_FREE,  0,       0,    0, ST_OK,        0,   0}
  };

  // lc, min block: extremes and out-of-range level counts
  int phase_lc[]   = '{10, 4, 0, 15, 1, 10, 7, 10, 2};
  int phase_minb[] = '{64, 1, 4096, 8191, 100, 0, 3, 4096, 4095};

  initial begin
    in_t  req;
    out_t res;
    int   per_phase, pick, shift;
    foreach (tree_busy[i]) tree_busy[i] = 1'b0;
    lvl_cfg = RST_LEVEL_COUNT;
    minb_cfg = RST_MIN_BLOCK;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_LEVEL_COUNT, 10);
    write_reg(CFG_MIN_BLOCK, 64);

    foreach (dir_rows[i]) begin
      req = '0;
      req.op = dir_rows[i].op;
      req.request_bytes = REQ_W'(dir_rows[i].bytes);
      req.node_index = NODE_W'(dir_rows[i].node);
      res = '0;
      res.status = dir_rows[i].st;
      res.granted_node = NODE_W'(dir_rows[i].gnode);
      res.granted_level = LVL_W'(dir_rows[i].glvl);
      send_request(req, dir_rows[i].typed, res);
    end
    live_nodes.delete();

    per_phase = RANDOM_ITEMS / phase_lc.size();
    foreach (phase_lc[ph]) begin
      drain();
      write_reg(CFG_LEVEL_COUNT, phase_lc[ph]);
      write_reg(CFG_MIN_BLOCK, phase_minb[ph]);
      for (int i = 0; i < per_phase; i++) begin
        quiet = (ph == 3);
        // in phase 1 only, hold off once mid-phase until the allocator has caught up
        if (ph == 1 && i == per_phase / 2) begin
          while (grant_q.size() != 0) @(posedge clk);
        end
        req = in_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          req.op = OP_ALLOC;
          shift = $urandom_range(0, REQ_W);
          req.request_bytes = REQ_W'($urandom & ((1 << shift) - 1));
        end else if (pick < 90 && live_nodes.size() != 0) begin
          int j;
          j = $urandom_range(0, live_nodes.size() - 1);
          req.op = OP_FREE;
          req.node_index = NODE_W'(live_nodes[j]);
          live_nodes.delete(j);
        end else begin
          req.op = OP_FREE;   // noise: any index
        end
        send_request(req, 1'b0, '0);
      end
      quiet = 0;
    end

    drain();
    if (failed || grant_q.size() != 0) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

endmodule
`default_nettype wire
